// ===== hdl/plc_pkg.sv =====
// Package: shared types, constants and state codes of the calibration block.
`timescale 1ns / 1ps
package plc_pkg;

	localparam int unsigned MAX_POINTS_DEF = 16;
	localparam int unsigned X_W = 16;
	localparam int unsigned R_W = 20;
	localparam int unsigned OUT_W = 32;
	localparam int unsigned CNT_W = 5;
	localparam int unsigned SEG_W = 4;
	localparam int unsigned REG_W = 2;
	localparam int unsigned ENTRY_W = X_W + R_W;
	// dy is 21 bits signed, numerator 17 bits signed
	localparam int unsigned DY_W = R_W + 1;
	localparam int unsigned NUM_W = X_W + 1;
	localparam int unsigned PROD_W = DY_W + NUM_W;
	localparam int unsigned QUO_W = PROD_W;

	localparam logic [REG_W-1:0] REGION_BELOW = 2'd0;
	localparam logic [REG_W-1:0] REGION_INSIDE = 2'd1;
	localparam logic [REG_W-1:0] REGION_ABOVE = 2'd2;

	localparam logic MODE_CONVERT = 1'b0;
	localparam logic MODE_LOAD = 1'b1;

	localparam logic [0:0] REG_POINTS_IN_USE = 1'b0;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD0,
		ST_CHK0,
		ST_RDMID,
		ST_RDNXT,
		ST_EVAL,
		ST_RDA,
		ST_RDB,
		ST_SETUP,
		ST_DIV,
		ST_FIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic neg;
		logic [PROD_W-1:0] dividend;
		logic [X_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [QUO_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== hdl/plc_ram.sv =====
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module plc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write or read one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ===== hdl/plc_div.sv =====
// Serial restoring divider: unsigned magnitude over unsigned divisor, signed quotient.
`timescale 1ns / 1ps
module plc_div (
	input  logic clk,
	input  logic arst_n,
	input  plc_pkg::div_req_t req,
	output plc_pkg::div_rsp_t rsp
);
	import plc_pkg::*;

	localparam int unsigned STEP_W = $clog2(PROD_W + 1);

	logic [PROD_W-1:0] quo_q;
	logic [X_W:0] rem_q;
	logic [X_W-1:0] dvs_q;
	logic neg_q;
	logic busy_q;
	logic done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [X_W+1:0] trial;
	logic [X_W:0] shifted;

	assign shifted = {rem_q[X_W-1:0], quo_q[PROD_W-1]};
	assign trial = {1'b0, shifted} - {2'b00, dvs_q};

	// one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= STEP_W'(PROD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
			neg_q <= req.neg;
		end else if (busy_q) begin
			if (!trial[X_W+1]) begin
				rem_q <= trial[X_W:0];
				quo_q <= {quo_q[PROD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[PROD_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quotient = neg_q ? (~quo_q + 1'b1) : quo_q;
endmodule

// ===== hdl/piecewise_linear_calibration.sv =====
// Top level: table memory, binary search sequencer and interpolation datapath.
// Sequence: a conversion reads the first point, binary searches the table, reads
// the two points of the segment, then runs the 38-step serial divider before
// out_valid rises.
// Throughput: a conversion stalls the input until its result is taken; loads are
// accepted one per cycle, back to back.
// Reset: control clears; a clearing pass over all MAX_POINTS entries zeroes the
// table, during which no item is accepted. points_in_use resets to 16.
`timescale 1ns / 1ps
module piecewise_linear_calibration #(
	parameter int unsigned MAX_POINTS = plc_pkg::MAX_POINTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_stall,
	input  logic mode,
	input  logic [3:0] point_index,
	input  logic [15:0] measured_value,
	input  logic signed [19:0] real_value,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [31:0] converted,
	output logic [3:0] segment,
	output logic [1:0] region,
	output logic fault
);
	import plc_pkg::*;

	localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int unsigned IW = AW + 2;

	state_t state_q, state_d;

	logic [CNT_W-1:0] piu_q;
	logic [AW-1:0] clr_q;
	logic [X_W-1:0] x_q;
	logic signed [IW-1:0] lo_q, hi_q, mid_q, n_q;
	logic [X_W-1:0] am_q;
	logic signed [IW-1:0] seg_q;
	logic [REG_W-1:0] reg_q;
	logic [X_W-1:0] ma_q;
	logic signed [R_W-1:0] ra_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [R_W-1:0] base_q;
	logic zero_q;
	logic signed [OUT_W-1:0] conv_q;
	logic [SEG_W-1:0] segout_q;
	logic [REG_W-1:0] regout_q;
	logic fault_q;
	logic valid_q;

	logic ram_we;
	logic [AW-1:0] ram_addr;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
	logic [X_W-1:0] rd_m;
	logic signed [R_W-1:0] rd_r;
	div_req_t dreq;
	div_rsp_t drsp;

	plc_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_POINTS)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	plc_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign rd_m = ram_rdata[ENTRY_W-1:R_W];
	assign rd_r = ram_rdata[R_W-1:0];

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_POINTS_IN_USE) ? {{(32-CNT_W){1'b0}}, piu_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			piu_q <= CNT_W'(16);
		end else if (psel && penable && pwrite && paddr[2] == REG_POINTS_IN_USE) begin
			piu_q <= pwdata[CNT_W-1:0];
		end
	end

	logic in_acc, out_acc;
	logic signed [IW-1:0] used_n, mid_c, hi_n, lo_n;
	logic ge_mid, lt_nxt, last_mid;

	assign in_stall = (state_q != ST_IDLE) || valid_q;
	assign in_acc = in_valid && !in_stall;
	assign out_acc = valid_q && !out_stall;

	// clamp point count into [2, MAX_POINTS]
	always_comb begin
		if (piu_q < CNT_W'(2)) used_n = IW'(2);
		else if (32'(piu_q) > MAX_POINTS) used_n = IW'(MAX_POINTS);
		else used_n = IW'(piu_q);
	end

	assign mid_c = (lo_q + hi_q) >>> 1;
	assign last_mid = (mid_q + IW'(1) >= n_q);
	assign ge_mid = (x_q >= am_q);
	assign lt_nxt = last_mid || (x_q < rd_m);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == AW'(MAX_POINTS - 1)) state_d = ST_IDLE;
			ST_IDLE: if (in_acc && mode == MODE_CONVERT) state_d = ST_RD0;
			ST_RD0: state_d = ST_CHK0;
			ST_CHK0: state_d = (x_q < rd_m) ? ST_RDA : ST_RDMID;
			ST_RDMID: begin
				if (lo_q > hi_q) state_d = ST_RDA;
				else state_d = ST_RDNXT;
			end
			ST_RDNXT: state_d = ST_EVAL;
			ST_EVAL: begin
				if (ge_mid && lt_nxt) state_d = ST_RDA;
				else state_d = ST_RDMID;
			end
			ST_RDA: state_d = ST_RDB;
			ST_RDB: state_d = ST_SETUP;
			ST_SETUP: state_d = ST_DIV;
			ST_DIV: if (drsp.done) state_d = ST_FIN;
			ST_FIN: state_d = ST_OUT;
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// memory address and write
	always_comb begin
		ram_we = 1'b0;
		ram_addr = '0;
		ram_wdata = {measured_value, real_value};
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				ram_addr = clr_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				ram_we = in_acc && mode == MODE_LOAD && 32'(point_index) < MAX_POINTS;
				ram_addr = AW'(point_index);
			end
			ST_RDMID: ram_addr = AW'(mid_c);
			ST_RDNXT: ram_addr = last_mid ? AW'(mid_q) : AW'(mid_q + IW'(1));
			ST_RDA: ram_addr = AW'(seg_q);
			ST_RDB: ram_addr = AW'(seg_q + IW'(1));
			default: ram_addr = '0;
		endcase
	end

	// search bookkeeping
	assign hi_n = mid_q - IW'(1);
	assign lo_n = mid_q + IW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == ST_OUT) valid_q <= 1'b1;
			else if (out_acc) valid_q <= 1'b0;
		end
	end

	logic signed [DY_W-1:0] dy;
	logic signed [NUM_W-1:0] num;
	logic signed [X_W:0] dx;
	logic signed [X_W:0] dx_q;
	logic signed [PROD_W-1:0] prod_c;
	logic signed [PROD_W+1:0] sum_c;

	// span is signed: a table that does not ascend gives a negative one
	assign dy = DY_W'(rd_r) - DY_W'(ra_q);
	assign dx = {1'b0, rd_m} - {1'b0, ma_q};
	assign num = (reg_q == REGION_INSIDE) ? (NUM_W'(x_q) - NUM_W'(ma_q)) : NUM_W'(x_q);
	assign prod_c = PROD_W'(dy) * PROD_W'(num);

	// start the divider once the product and span are registered
	assign dreq.start = (state_q == ST_DIV) && !drsp.busy && !drsp.done;
	assign dreq.neg = prod_q[PROD_W-1] ^ dx_q[X_W];
	assign dreq.dividend = prod_q[PROD_W-1] ? (~prod_q + 1'b1) : prod_q;
	assign dreq.divisor = dx_q[X_W] ? X_W'(-dx_q) : dx_q[X_W-1:0];

	assign sum_c = (PROD_W+2)'(signed'(drsp.quotient)) + (PROD_W+2)'(base_q);

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q <= measured_value;
				n_q <= used_n;
				lo_q <= '0;
				hi_q <= used_n - IW'(1);
			end
			ST_CHK0: begin
				if (x_q < rd_m) begin
					seg_q <= '0;
					reg_q <= REGION_BELOW;
				end
			end
			ST_RDMID: begin
				mid_q <= mid_c;
				if (lo_q > hi_q) begin
					if (lo_q == n_q - IW'(1)) begin
						seg_q <= n_q - IW'(2);
						reg_q <= REGION_ABOVE;
					end else begin
						seg_q <= '0;
						reg_q <= REGION_BELOW;
					end
				end
			end
			ST_RDNXT: am_q <= rd_m;
			ST_EVAL: begin
				if (ge_mid && lt_nxt) begin
					if (mid_q == n_q - IW'(1)) begin
						seg_q <= n_q - IW'(2);
						reg_q <= REGION_ABOVE;
					end else begin
						seg_q <= mid_q;
						reg_q <= REGION_INSIDE;
					end
				end else if (!ge_mid) begin
					hi_q <= hi_n;
				end else begin
					lo_q <= lo_n;
				end
			end
			ST_RDB: begin
				ma_q <= rd_m;
				ra_q <= rd_r;
			end
			ST_SETUP: ;
			ST_FIN: begin
				if (zero_q) begin
					conv_q <= '0;
					fault_q <= 1'b1;
				end else if (sum_c > (PROD_W+2)'(33'sh0_7FFF_FFFF)) begin
					conv_q <= 32'sh7FFF_FFFF;
					fault_q <= 1'b1;
				end else if (sum_c < -(PROD_W+2)'(33'sh0_8000_0000)) begin
					conv_q <= 32'sh8000_0000;
					fault_q <= 1'b1;
				end else begin
					conv_q <= sum_c[OUT_W-1:0];
					fault_q <= 1'b0;
				end
				segout_q <= SEG_W'(seg_q);
				regout_q <= reg_q;
			end
			default: ;
		endcase
		// product and span are formed when the upper point arrives
		if (state_q == ST_SETUP) begin
			prod_q <= prod_c;
			dx_q <= dx;
			zero_q <= (dx == '0);
			base_q <= (reg_q == REGION_INSIDE) ? ra_q : '0;
		end
	end

	assign out_valid = valid_q;
	assign converted = conv_q;
	assign segment = segout_q;
	assign region = regout_q;
	assign fault = fault_q;

	// no item is taken while a result waits
	a_no_accept_pending: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> in_stall) else $error("item accepted with result pending");
	// divider runs only during its state
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.busy |-> (state_q == ST_DIV)) else $error("divider busy outside divide");
	// a result appears right after the output state
	a_out_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |=> valid_q) else $error("result not raised");
	// region code is never three
	a_region: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (regout_q != 2'd3)) else $error("bad region");
endmodule
